// File: hw/rtl/nss_pkg.sv
// ----------------------------------------------------------------------------
// nss_pkg
// shared constants and types for the nested sweep capture sequencer
// ----------------------------------------------------------------------------
package nss_pkg;

  localparam int LEVEL_BITS_DEF  = 16;
  localparam int SAMPLE_BITS_DEF = 12;
  localparam int POS_BITS        = 16;
  localparam int CFG_ADDR_BITS   = 3;

  // register defaults
  localparam logic [31:0] INNER_STEP_RST = 32'h0000_0020;
  localparam logic [31:0] INNER_STOP_RST = 32'h0000_1000;
  localparam logic [31:0] OUTER_STEP_RST = 32'h0000_0200;
  localparam logic [31:0] OUTER_STOP_RST = 32'h0000_1000;

  // register indexes
  localparam logic [CFG_ADDR_BITS-1:0] REG_INNER_START = 3'd0;
  localparam logic [CFG_ADDR_BITS-1:0] REG_INNER_STEP  = 3'd1;
  localparam logic [CFG_ADDR_BITS-1:0] REG_INNER_STOP  = 3'd2;
  localparam logic [CFG_ADDR_BITS-1:0] REG_OUTER_START = 3'd3;
  localparam logic [CFG_ADDR_BITS-1:0] REG_OUTER_STEP  = 3'd4;
  localparam logic [CFG_ADDR_BITS-1:0] REG_OUTER_STOP  = 3'd5;

  // input modes
  localparam logic [1:0] MODE_START  = 2'd0;
  localparam logic [1:0] MODE_TICK   = 2'd1;
  localparam logic [1:0] MODE_SAMPLE = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_LEVEL     = 2'd0;
  localparam logic [1:0] KIND_SAMPLE    = 2'd1;
  localparam logic [1:0] KIND_LINE_END  = 2'd2;
  localparam logic [1:0] KIND_SWEEP_END = 2'd3;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_ACTIVE = 2'd1,
    PH_START  = 2'd2
  } phase_t;

  // how many result beats one item pushes into the output queue
  typedef struct packed {
    logic one;
    logic two;
  } push_t;

endpackage

// File: hw/rtl/nss_core.sv
// ----------------------------------------------------------------------------
// nss_core
// sweep state, config registers and per-item result generation
// ----------------------------------------------------------------------------
module nss_core #(
  parameter int LEVEL_BITS  = 16,
  parameter int SAMPLE_BITS = 12,
  parameter int BEAT_W      = 3 + 2*LEVEL_BITS + SAMPLE_BITS + 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [nss_pkg::CFG_ADDR_BITS-1:0] cfg_addr,
  input  logic [LEVEL_BITS-1:0]           cfg_wdata,
  input  logic                            item_acc,
  input  logic [1:0]                      item_mode,
  input  logic [SAMPLE_BITS-1:0]          item_sample,
  output nss_pkg::push_t                  push,
  output logic [BEAT_W-1:0]               beat0,
  output logic [BEAT_W-1:0]               beat1
);
  import nss_pkg::*;

  logic [LEVEL_BITS-1:0] inner_start_r, inner_step_r, inner_stop_r;
  logic [LEVEL_BITS-1:0] outer_start_r, outer_step_r, outer_stop_r;

  phase_t                phase_r, phase_nxt;
  logic                  ticking_r, ticking_nxt;
  logic [LEVEL_BITS-1:0] inner_r, inner_nxt;
  logic [LEVEL_BITS-1:0] outer_r, outer_nxt;
  logic                  line_done_r, line_done_nxt;
  logic                  sweep_done_r, sweep_done_nxt;
  logic [POS_BITS-1:0]   idx_r, idx_nxt;

  logic [LEVEL_BITS-1:0] inner_add, outer_add;
  logic                  inner_over, outer_over;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inner_start_r <= '0;
      inner_step_r  <= INNER_STEP_RST[LEVEL_BITS-1:0];
      inner_stop_r  <= INNER_STOP_RST[LEVEL_BITS-1:0];
      outer_start_r <= '0;
      outer_step_r  <= OUTER_STEP_RST[LEVEL_BITS-1:0];
      outer_stop_r  <= OUTER_STOP_RST[LEVEL_BITS-1:0];
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_INNER_START: inner_start_r <= cfg_wdata;
        REG_INNER_STEP:  inner_step_r  <= cfg_wdata;
        REG_INNER_STOP:  inner_stop_r  <= cfg_wdata;
        REG_OUTER_START: outer_start_r <= cfg_wdata;
        REG_OUTER_STEP:  outer_step_r  <= cfg_wdata;
        REG_OUTER_STOP:  outer_stop_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // both ramps stepped in parallel, picked below
  assign inner_add  = inner_r + inner_step_r;
  assign outer_add  = outer_r + outer_step_r;
  assign inner_over = inner_add > inner_stop_r;
  assign outer_over = outer_add > outer_stop_r;

  always_comb begin
    phase_nxt      = phase_r;
    ticking_nxt    = ticking_r;
    inner_nxt      = inner_r;
    outer_nxt      = outer_r;
    line_done_nxt  = line_done_r;
    sweep_done_nxt = sweep_done_r;
    idx_nxt        = idx_r;
    push           = '0;
    beat0          = '0;
    beat1          = '0;

    if (item_acc) begin
      case (item_mode)
        MODE_START: begin
          phase_nxt      = PH_START;
          ticking_nxt    = 1'b1;
          idx_nxt        = '0;
          line_done_nxt  = 1'b0;
          sweep_done_nxt = 1'b0;
        end
        MODE_TICK: begin
          if (ticking_r) begin
            if (phase_r == PH_START) begin
              idx_nxt   = '0;
              inner_nxt = inner_start_r;
              outer_nxt = outer_start_r;
              phase_nxt = PH_ACTIVE;
            end else if (inner_over) begin
              line_done_nxt = 1'b1;
              inner_nxt     = inner_start_r;
              if (outer_over) begin
                outer_nxt      = outer_start_r;
                sweep_done_nxt = 1'b1;
              end else begin
                outer_nxt = outer_add;
              end
            end else begin
              inner_nxt = inner_add;
            end
            push.one = 1'b1;
            beat0    = {1'b1, KIND_LEVEL, {POS_BITS{1'b0}}, {SAMPLE_BITS{1'b0}},
                        outer_nxt, inner_nxt};
          end
        end
        MODE_SAMPLE: begin
          if (phase_r == PH_ACTIVE) begin
            push.one = 1'b1;
            if (!line_done_r) begin
              beat0 = {1'b1, KIND_SAMPLE, idx_r, item_sample,
                       {LEVEL_BITS{1'b0}}, {LEVEL_BITS{1'b0}}};
              if (idx_r != {POS_BITS{1'b1}}) idx_nxt = idx_r + 1'b1;
            end else begin
              idx_nxt = '0;
              if (!sweep_done_r) begin
                line_done_nxt = 1'b0;
                beat0 = {1'b1, KIND_LINE_END, idx_r, {SAMPLE_BITS{1'b0}},
                         {LEVEL_BITS{1'b0}}, {LEVEL_BITS{1'b0}}};
              end else begin
                inner_nxt   = inner_start_r;
                outer_nxt   = outer_start_r;
                phase_nxt   = PH_IDLE;
                ticking_nxt = 1'b0;
                push.two    = 1'b1;
                beat0 = {1'b0, KIND_LINE_END, idx_r, {SAMPLE_BITS{1'b0}},
                         {LEVEL_BITS{1'b0}}, {LEVEL_BITS{1'b0}}};
                beat1 = {1'b1, KIND_SWEEP_END, {POS_BITS{1'b0}},
                         {SAMPLE_BITS{1'b0}}, outer_start_r, inner_start_r};
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      ticking_r    <= 1'b0;
      inner_r      <= '0;
      outer_r      <= '0;
      line_done_r  <= 1'b0;
      sweep_done_r <= 1'b0;
      idx_r        <= '0;
    end else begin
      phase_r      <= phase_nxt;
      ticking_r    <= ticking_nxt;
      inner_r      <= inner_nxt;
      outer_r      <= outer_nxt;
      line_done_r  <= line_done_nxt;
      sweep_done_r <= sweep_done_nxt;
      idx_r        <= idx_nxt;
    end
  end

endmodule

// File: hw/rtl/nss_outq.sv
// ----------------------------------------------------------------------------
// nss_outq
// four-beat result queue, takes one or two beats per cycle
// ----------------------------------------------------------------------------
module nss_outq #(
  parameter int BEAT_W = 63
) (
  input  logic              clk,
  input  logic              rst_n,
  input  nss_pkg::push_t    push,
  input  logic [BEAT_W-1:0] beat0,
  input  logic [BEAT_W-1:0] beat1,
  input  logic              pop,
  output logic              not_empty,
  output logic              room_two,
  output logic [BEAT_W-1:0] head
);
  import nss_pkg::*;

  logic [BEAT_W-1:0] mem_r [4];
  logic [1:0]        wp_r, rp_r;
  logic [2:0]        cnt_r;
  logic [2:0]        n_push;
  logic              do_pop;

  assign not_empty = cnt_r != 3'd0;
  assign room_two  = cnt_r <= 3'd2;
  assign head      = mem_r[rp_r];
  assign do_pop    = pop && not_empty;
  assign n_push    = push.two ? 3'd2 : (push.one ? 3'd1 : 3'd0);

  always_ff @(posedge clk) begin
    if (push.one) mem_r[wp_r] <= beat0;
    if (push.two) mem_r[wp_r + 2'd1] <= beat1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_r + n_push[1:0];
      if (do_pop) rp_r <= rp_r + 2'd1;
      cnt_r <= cnt_r + n_push - {2'b00, do_pop};
    end
  end

endmodule

// File: hw/rtl/nested_sweep_capture_sequencer_unit.sv
// ----------------------------------------------------------------------------
// nested_sweep_capture_sequencer_unit
// two-level curve tracer sweep controller with sample capture
// ----------------------------------------------------------------------------
// One input beat is taken per clock whenever the output queue has two free
// slots. Each item is resolved in the cycle it is accepted (an add, a compare
// and a select per ramp) and its results land in a four-beat output queue, so
// a result on out_ is always registered, never taken straight from in_. A tick or a
// sample yields one beat; a sample that closes the final line yields two (line
// end then sweep end), so the sustained rate is one item per cycle as long as
// the sink keeps up, limited only by the queue's two-slot admission rule.
// Start items and ignored items produce no beat. Config writes take effect on
// the next clock and are meant to happen while the block is idle.
module nested_sweep_capture_sequencer_unit #(
  parameter int LEVEL_BITS  = nss_pkg::LEVEL_BITS_DEF,
  parameter int SAMPLE_BITS = nss_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // config write port
  input  logic                                  cfg_we,
  input  logic [nss_pkg::CFG_ADDR_BITS-1:0]     cfg_addr,
  input  logic [LEVEL_BITS-1:0]                 cfg_wdata,
  // input beats
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]      in_tdata,  // sample
  input  logic [1:0]                            in_tuser,  // mode
  // result beats
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // inner_level, outer_level, sample_value, position
  output logic [((2*LEVEL_BITS+SAMPLE_BITS+nss_pkg::POS_BITS+7)/8)*8-1:0] out_tdata,
  output logic [1:0]                            out_tuser, // kind
  output logic                                  out_tlast
);
  import nss_pkg::*;

  localparam int FIELDS_W   = 2*LEVEL_BITS + SAMPLE_BITS + POS_BITS;
  localparam int OUT_DATA_W = ((FIELDS_W + 7) / 8) * 8;
  // queue entry: {last, kind, position, sample_value, outer_level, inner_level}
  localparam int BEAT_W     = FIELDS_W + 3;

  push_t             push;
  logic [BEAT_W-1:0] beat0, beat1, head;
  logic              room_two;
  logic              in_acc;

  // admit only with room for the worst case of two beats
  assign in_tready = room_two;
  assign in_acc    = in_tvalid && in_tready;

  nss_core #(
    .LEVEL_BITS  (LEVEL_BITS),
    .SAMPLE_BITS (SAMPLE_BITS),
    .BEAT_W      (BEAT_W)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_addr    (cfg_addr),
    .cfg_wdata   (cfg_wdata),
    .item_acc    (in_acc),
    .item_mode   (in_tuser),
    .item_sample (in_tdata[SAMPLE_BITS-1:0]),
    .push        (push),
    .beat0       (beat0),
    .beat1       (beat1)
  );

  nss_outq #(
    .BEAT_W (BEAT_W)
  ) u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .beat0     (beat0),
    .beat1     (beat1),
    .pop       (out_tready),
    .not_empty (out_tvalid),
    .room_two  (room_two),
    .head      (head)
  );

  // unpack the queue head onto the stream fields
  assign out_tdata = OUT_DATA_W'(head[FIELDS_W-1:0]);
  assign out_tuser = head[FIELDS_W+1:FIELDS_W];
  assign out_tlast = head[FIELDS_W+2];

endmodule

// File: hw/rtl/nss_checker.sv
// ----------------------------------------------------------------------------
// nss_checker
// port-level checks on the sweep sequencer, bound to the top level
// ----------------------------------------------------------------------------
module nss_checker #(
  parameter int LEVEL_BITS  = 16,
  parameter int SAMPLE_BITS = 12
) (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 out_tvalid,
  input logic                                 out_tready,
  input logic [((2*LEVEL_BITS+SAMPLE_BITS+nss_pkg::POS_BITS+7)/8)*8-1:0] out_tdata,
  input logic [1:0]                           out_tuser,
  input logic                                 out_tlast
);
  import nss_pkg::*;

  localparam int SMP_LO = 2*LEVEL_BITS;
  localparam int POS_LO = 2*LEVEL_BITS + SAMPLE_BITS;

  // queue comes out of reset empty
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result beat shown right after reset");

  // a stalled beat stays offered
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result beat withdrawn while stalled");

  // only a line end can be followed by another beat of the same item
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != KIND_LINE_END |-> out_tlast)
    else $error("non line end beat without last");

  // level updates carry no sample or position
  a_level_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_LEVEL |->
      out_tdata[POS_LO+POS_BITS-1:SMP_LO] == '0)
    else $error("level update with sample fields set");

endmodule

bind nested_sweep_capture_sequencer_unit nss_checker #(
  .LEVEL_BITS  (LEVEL_BITS),
  .SAMPLE_BITS (SAMPLE_BITS)
) u_nss_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

// File: tb/tb_nested_sweep_capture_sequencer_unit.sv
// ----------------------------------------------------------------------------
// tb_nested_sweep_capture_sequencer_unit
// Self-checking bench for the two-level sweep sequencer. A short table of
// directed beats comes first: ignored items, arming, the first level load,
// level wrap, a line end followed by a sweep end, and a restart. Random
// sweeps follow under fresh ramp settings. Every accepted result beat is
// checked field by field against its table row or an in-bench model of the sweep state.
// ----------------------------------------------------------------------------
module tb_nested_sweep_capture_sequencer_unit;
  import nss_pkg::*;

  localparam int         CLK_HALF       = 4;
  localparam int         DRAIN_CYCLES   = 6;
  localparam int         LIMIT_CYCLES   = 500_000;
  localparam int         RANDOM_PHASES  = 6;
  localparam int         PHASE_ITEMS    = 33;
  localparam logic [1:0] MODE_NONE      = 2'd3;   // unused mode, always ignored

  // one result beat as the sink sees it
  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] inner_level;
    logic [15:0] outer_level;
    logic [11:0] sample_value;
    logic [15:0] position;
    logic        last;
  } sweep_beat_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_op_t;

  // directed row: an item (sel = mode, val = sample) or a register write
  // (sel = index, val = data); typed rows carry their one result beat
  typedef struct packed {
    row_op_t     op;
    logic [2:0]  sel;
    logic [15:0] val;
    logic        typed;
    logic [1:0]  e_kind;
    logic [15:0] e_inner;
    logic [15:0] e_outer;
    logic [11:0] e_sample;
    logic [15:0] e_pos;
  } plan_row_t;

  localparam int PLAN_ROWS = 36;
  localparam plan_row_t PLAN [PLAN_ROWS] = '{
    // reset settings: nothing armed, so ticks, samples and mode 3 are ignored
    '{ROW_ITEM, MODE_TICK,   16'h0000, 1'b0, KIND_LEVEL,  16'h0000, 16'h0000, 12'h000, 16'h0},
    '{ROW_ITEM, MODE_SAMPLE, 16'h0ABC, 1'b0, KIND_LEVEL,  16'h0000, 16'h0000, 12'h000, 16'h0},
    '{ROW_ITEM, MODE_NONE,   16'h0FFF, 1'b0, KIND_LEVEL,  16'h0000, 16'h0000, 12'h000, 16'h0},
    '{ROW_ITEM, MODE_START,  16'h0FFF, 1'b0, KIND_LEVEL,  16'h0000, 16'h0000, 12'h000, 16'h0},
    // armed but not active yet: sample dropped silently
    '{ROW_ITEM, MODE_SAMPLE, 16'h0123, 1'b0, KIND_LEVEL,  16'h0000, 16'h0000, 12'h000, 16'h0},
    // first tick loads both starts, the next one steps the inner ramp
    '{ROW_ITEM, MODE_TICK,   16'h0000, 1'b1, KIND_LEVEL,  16'h0000, 16'h0000, 12'h000, 16'h0},
    '{ROW_ITEM, MODE_TICK,   16'h0000, 1'b1, KIND_LEVEL,  16'h0020, 16'h0000, 12'h000, 16'h0},
    '{ROW_ITEM, MODE_SAMPLE, 16'h0FFF, 1'b1, KIND_SAMPLE, 16'h0000, 16'h0000, 12'hFFF, 16'h0},
    '{ROW_ITEM, MODE_SAMPLE, 16'h0000, 1'b1, KIND_SAMPLE, 16'h0000, 16'h0000, 12'h000, 16'h1},
    '{ROW_ITEM, MODE_NONE,   16'h0000, 1'b0, KIND_LEVEL,  16'h0000, 16'h0000, 12'h000, 16'h0},
    // one inner step past the stop also pushes the outer ramp past its stop
    '{ROW_CFG,  REG_INNER_START, 16'hFFFE, 1'b0, KIND_LEVEL, 16'h0, 16'h0, 12'h0, 16'h0},
    '{ROW_CFG,  REG_INNER_STEP,  16'h0001, 1'b0, KIND_LEVEL, 16'h0, 16'h0, 12'h0, 16'h0},
    '{ROW_CFG,  REG_INNER_STOP,  16'hFFFE, 1'b0, KIND_LEVEL, 16'h0, 16'h0, 12'h0, 16'h0},
    '{ROW_CFG,  REG_OUTER_START, 16'h0000, 1'b0, KIND_LEVEL, 16'h0, 16'h0, 12'h0, 16'h0},
    '{ROW_CFG,  REG_OUTER_STEP,  16'hFFFF, 1'b0, KIND_LEVEL, 16'h0, 16'h0, 12'h0, 16'h0},
    '{ROW_CFG,  REG_OUTER_STOP,  16'h0000, 1'b0, KIND_LEVEL, 16'h0, 16'h0, 12'h0, 16'h0},
    '{ROW_ITEM, MODE_START,  16'h0000, 1'b0, KIND_LEVEL,  16'h0000, 16'h0000, 12'h000, 16'h0},
    '{ROW_ITEM, MODE_TICK,   16'h0000, 1'b1, KIND_LEVEL,  16'hFFFE, 16'h0000, 12'h000, 16'h0},
    '{ROW_ITEM, MODE_SAMPLE, 16'h0555, 1'b1, KIND_SAMPLE, 16'h0000, 16'h0000, 12'h555, 16'h0},
    // line and sweep end marked, ticks keep stepping while the end is pending
    '{ROW_ITEM, MODE_TICK,   16'h0000, 1'b0, KIND_LEVEL,  16'h0000, 16'h0000, 12'h000, 16'h0},
    '{ROW_ITEM, MODE_TICK,   16'h0000, 1'b0, KIND_LEVEL,  16'h0000, 16'h0000, 12'h000, 16'h0},
    // sample closes the last line: line end then sweep end
    '{ROW_ITEM, MODE_SAMPLE, 16'h0AAA, 1'b0, KIND_LEVEL,  16'h0000, 16'h0000, 12'h000, 16'h0},
    '{ROW_ITEM, MODE_TICK,   16'h0000, 1'b0, KIND_LEVEL,  16'h0000, 16'h0000, 12'h000, 16'h0},
    '{ROW_ITEM, MODE_SAMPLE, 16'h0FFF, 1'b0, KIND_LEVEL,  16'h0000, 16'h0000, 12'h000, 16'h0},
    // top of range: inner lands on its stop exactly, outer never moves
    '{ROW_CFG,  REG_INNER_START, 16'h0000, 1'b0, KIND_LEVEL, 16'h0, 16'h0, 12'h0, 16'h0},
    '{ROW_CFG,  REG_INNER_STEP,  16'hFFFF, 1'b0, KIND_LEVEL, 16'h0, 16'h0, 12'h0, 16'h0},
    '{ROW_CFG,  REG_INNER_STOP,  16'hFFFF, 1'b0, KIND_LEVEL, 16'h0, 16'h0, 12'h0, 16'h0},
    '{ROW_CFG,  REG_OUTER_START, 16'hFFFF, 1'b0, KIND_LEVEL, 16'h0, 16'h0, 12'h0, 16'h0},
    '{ROW_CFG,  REG_OUTER_STEP,  16'h0000, 1'b0, KIND_LEVEL, 16'h0, 16'h0, 12'h0, 16'h0},
    '{ROW_CFG,  REG_OUTER_STOP,  16'hFFFF, 1'b0, KIND_LEVEL, 16'h0, 16'h0, 12'h0, 16'h0},
    '{ROW_ITEM, MODE_START,  16'h0000, 1'b0, KIND_LEVEL,  16'h0000, 16'h0000, 12'h000, 16'h0},
    '{ROW_ITEM, MODE_TICK,   16'h0000, 1'b1, KIND_LEVEL,  16'h0000, 16'hFFFF, 12'h000, 16'h0},
    '{ROW_ITEM, MODE_TICK,   16'h0000, 1'b0, KIND_LEVEL,  16'h0000, 16'h0000, 12'h000, 16'h0},
    // restart in the middle of a line reloads the starts
    '{ROW_ITEM, MODE_START,  16'h0000, 1'b0, KIND_LEVEL,  16'h0000, 16'h0000, 12'h000, 16'h0},
    '{ROW_ITEM, MODE_TICK,   16'h0000, 1'b1, KIND_LEVEL,  16'h0000, 16'hFFFF, 12'h000, 16'h0},
    '{ROW_ITEM, MODE_SAMPLE, 16'h0FFF, 1'b1, KIND_SAMPLE, 16'h0000, 16'h0000, 12'hFFF, 16'h0}
  };

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        cfg_we     = 1'b0;
  logic [2:0]  cfg_addr   = '0;
  logic [15:0] cfg_wdata  = '0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata   = '0;   // sample [11:0], zero padding above
  logic [1:0]  in_tuser   = '0;   // mode
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;         // inner_level, outer_level, sample_value, position
  logic [1:0]  out_tuser;         // kind
  logic        out_tlast;

  // ramp settings as last written
  logic [15:0] ramp_inner_start = 16'h0000;
  logic [15:0] ramp_inner_step  = INNER_STEP_RST[15:0];
  logic [15:0] ramp_inner_stop  = INNER_STOP_RST[15:0];
  logic [15:0] ramp_outer_start = 16'h0000;
  logic [15:0] ramp_outer_step  = OUTER_STEP_RST[15:0];
  logic [15:0] ramp_outer_stop  = OUTER_STOP_RST[15:0];

  // sweep state as the bench sees it
  phase_t      sweep_phase   = PH_IDLE;
  logic        sweep_armed   = 1'b0;
  logic [15:0] level_inner   = '0;
  logic [15:0] level_outer   = '0;
  logic        line_pending  = 1'b0;
  logic        sweep_pending = 1'b0;
  logic [15:0] capture_index = '0;

  sweep_beat_t fresh_beats [$];   // results of the item just taken
  sweep_beat_t awaited_beats [$]; // results still to come out, oldest first
  int          fail_count = 0;
  logic        calm = 1'b0;       // no idling on either side
  int          stall_left = 0;

  nested_sweep_capture_sequencer_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // work out the result beats of one accepted item and advance the sweep state
  function automatic void advance_sweep(input logic [1:0] mode, input logic [11:0] smp);
    case (mode)
      MODE_START: begin
        sweep_phase   = PH_START;
        sweep_armed   = 1'b1;
        capture_index = '0;
        line_pending  = 1'b0;
        sweep_pending = 1'b0;
      end
      MODE_TICK: begin
        if (sweep_armed) begin
          if (sweep_phase == PH_START) begin
            capture_index = '0;
            level_inner   = ramp_inner_start;
            level_outer   = ramp_outer_start;
            sweep_phase   = PH_ACTIVE;
          end else begin
            // 16-bit sums wrap on assignment
            level_inner = level_inner + ramp_inner_step;
            if (level_inner > ramp_inner_stop) begin
              line_pending = 1'b1;
              level_inner  = ramp_inner_start;
              level_outer  = level_outer + ramp_outer_step;
              if (level_outer > ramp_outer_stop) begin
                level_outer   = ramp_outer_start;
                sweep_pending = 1'b1;
              end
            end
          end
          fresh_beats.push_back(sweep_beat_t'{KIND_LEVEL, level_inner, level_outer,
                                              12'h000, 16'h0000, 1'b1});
        end
      end
      MODE_SAMPLE: begin
        if (sweep_phase == PH_ACTIVE) begin
          if (!line_pending) begin
            fresh_beats.push_back(sweep_beat_t'{KIND_SAMPLE, 16'h0000, 16'h0000,
                                                smp, capture_index, 1'b1});
            if (capture_index != 16'hFFFF) capture_index = capture_index + 16'd1;
          end else begin
            // this sample is dropped, the line closes with its count
            fresh_beats.push_back(sweep_beat_t'{KIND_LINE_END, 16'h0000, 16'h0000,
                                                12'h000, capture_index, !sweep_pending});
            capture_index = '0;
            if (!sweep_pending) begin
              line_pending = 1'b0;
            end else begin
              level_inner = ramp_inner_start;
              level_outer = ramp_outer_start;
              sweep_phase = PH_IDLE;
              sweep_armed = 1'b0;
              fresh_beats.push_back(sweep_beat_t'{KIND_SWEEP_END, level_inner, level_outer,
                                                  12'h000, 16'h0000, 1'b1});
            end
          end
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      fail_count++;
    end
  endfunction

  // present one beat, wait for the handshake, then record what it should cause
  task automatic send_item(input logic [1:0] mode, input logic [11:0] smp,
                           input logic typed, input sweep_beat_t typed_beat);
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 5);
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= {4'h0, smp};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    fresh_beats.delete();
    advance_sweep(mode, smp);
    if (typed) begin
      awaited_beats.push_back(typed_beat);
    end else begin
      foreach (fresh_beats[k]) awaited_beats.push_back(fresh_beats[k]);
    end
  endtask

  task automatic send_plain(input logic [1:0] mode, input logic [11:0] smp);
    send_item(mode, smp, 1'b0, '0);
  endtask

  // hold the input side until every awaited beat is out, then let items still in
  // flight that cause no beat drain
  task automatic wait_quiet();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (awaited_beats.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_INNER_START: ramp_inner_start = data;
      REG_INNER_STEP:  ramp_inner_step  = data;
      REG_INNER_STOP:  ramp_inner_stop  = data;
      REG_OUTER_START: ramp_outer_start = data;
      REG_OUTER_STEP:  ramp_outer_step  = data;
      REG_OUTER_STOP:  ramp_outer_stop  = data;
      default: ;
    endcase
  endtask

  // short ramps so lines and sweeps finish within a phase; wild ones take any value
  task automatic pick_ramps(input logic wild);
    logic [15:0] ist, isp, iso, ost, osp, oso;
    if (wild) begin
      ist = 16'($urandom); isp = 16'($urandom); iso = 16'($urandom);
      ost = 16'($urandom); osp = 16'($urandom); oso = 16'($urandom);
    end else begin
      ist = 16'($urandom_range(0, 16'hC000));
      isp = 16'($urandom_range(1, 16'h0800));
      iso = 16'(ist + isp * $urandom_range(0, 4));
      ost = 16'($urandom_range(0, 16'hC000));
      osp = 16'($urandom_range(1, 16'h0800));
      oso = 16'(ost + osp * $urandom_range(0, 2));
    end
    write_reg(REG_INNER_START, ist);
    write_reg(REG_INNER_STEP,  isp);
    write_reg(REG_INNER_STOP,  iso);
    write_reg(REG_OUTER_START, ost);
    write_reg(REG_OUTER_STEP,  osp);
    write_reg(REG_OUTER_STOP,  oso);
  endtask

  function automatic logic [11:0] pick_sample();
    int roll;
    roll = $urandom_range(0, 7);
    if (roll == 0) return 12'h000;
    if (roll == 1) return 12'hFFF;
    return 12'($urandom);
  endfunction

  // sink side: random stall bursts, none once calm
  always @(negedge clk) begin
    if (calm) begin
      out_tready <= 1'b1;
    end else if (stall_left != 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 4) == 0) begin
      out_tready <= 1'b0;
      stall_left <= $urandom_range(0, 4);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // result check, one beat per handshake against the oldest expectation
  always @(posedge clk) begin : result_check
    sweep_beat_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (awaited_beats.size() == 0) begin
        $error("result beat with none awaited: kind %0d", out_tuser);
        fail_count++;
      end else begin
        want = awaited_beats.pop_front();
        check_field("kind",         32'(want.kind),         32'(out_tuser));
        check_field("inner_level",  32'(want.inner_level),  32'(out_tdata[15:0]));
        check_field("outer_level",  32'(want.outer_level),  32'(out_tdata[31:16]));
        check_field("sample_value", 32'(want.sample_value), 32'(out_tdata[43:32]));
        check_field("position",     32'(want.position),     32'(out_tdata[59:44]));
        check_field("last",         32'(want.last),         32'(out_tlast));
      end
    end
  end

  initial begin : stimulus
    plan_row_t   row;
    logic [1:0]  mode;
    logic [11:0] smp;
    int          roll;

    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // directed table
    for (int r = 0; r < PLAN_ROWS; r++) begin
      row = PLAN[r];
      if (row.op == ROW_CFG) begin
        wait_quiet();
        write_reg(row.sel, row.val);
      end else begin
        send_item(row.sel[1:0], row.val[11:0], row.typed,
                  sweep_beat_t'{row.e_kind, row.e_inner, row.e_outer,
                                row.e_sample, row.e_pos, 1'b1});
      end
    end

    // random sweeps, each phase under its own ramp settings
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      wait_quiet();
      if (p == RANDOM_PHASES - 1) calm <= 1'b1;
      pick_ramps(p % 3 == 2);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // now and then let everything drain before the next beat
        if (!calm && $urandom_range(0, 49) == 0) wait_quiet();
        roll = $urandom_range(0, 99);
        smp  = pick_sample();
        if (!sweep_armed && roll < 70) mode = MODE_START;
        else if (roll < 45)            mode = MODE_TICK;
        else if (roll < 90)            mode = MODE_SAMPLE;
        else if (roll < 94)            mode = MODE_START;
        else if (roll < 97)            mode = MODE_NONE;
        else                           mode = 2'($urandom);
        send_plain(mode, smp);
      end
    end

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (awaited_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES * 2) @(posedge clk);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(LIMIT_CYCLES * 2 * CLK_HALF);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// File: nested_sweep_capture_sequencer_unit.f
hw/rtl/nss_pkg.sv
hw/rtl/nss_core.sv
hw/rtl/nss_outq.sv
hw/rtl/nested_sweep_capture_sequencer_unit.sv
hw/rtl/nss_checker.sv
tb/tb_nested_sweep_capture_sequencer_unit.sv
